@@ src/cdeq_pkg.sv @@
package cdeq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_SEARCH     = 3'd4;
  localparam logic [2:0] KIND_DUMP       = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_WRITE,
    CELL_ROTATE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    cnt_t               count;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

@@ src/cdeq_cell.sv @@
module cdeq_cell (
  input  logic                clk,
  input  cdeq_pkg::cell_ctl_t ctl,
  input  cdeq_pkg::idx_t      idx,
  input  logic signed [31:0]  left_d,
  input  logic signed [31:0]  right_d,
  input  logic signed [31:0]  head_d,
  output logic signed [31:0]  q
);
  import cdeq_pkg::*;

  cnt_t idx_ext;
  cnt_t idx_inc;

  assign idx_ext = cnt_t'(idx);
  assign idx_inc = idx_ext + cnt_t'(1);

  // rotate: the occupied prefix turns left by one, the head wrapping to the tail
  always_ff @(posedge clk) begin
    case (ctl.mode)
      CELL_TAKE_LEFT: q <= left_d;
      CELL_TAKE_RIGHT: q <= right_d;
      CELL_WRITE: begin
        if (idx_ext == ctl.count) q <= ctl.value;
      end
      CELL_ROTATE: begin
        if (idx_inc < ctl.count) q <= right_d;
        else if (idx_inc == ctl.count) q <= head_d;
      end
      default: ;
    endcase
  end

endmodule

@@ src/circular_deque_with_search.sv @@
// Bounded deque of DEPTH signed 32-bit values held in a row of cells, front
// in the first cell. An operation is taken when start is high and busy low.
// Pushes and pops each give a single result, which strobes on the following
// cycle. Search and dump walk the N stored elements: the occupied cells
// turn round once, one element past the head per cycle, with busy high
// throughout. Dump gives one result per cycle, front to back, the final
// one flagged by last; search gives one result after the walk. Results
// are valid for the single cycle that strobe is high; there is no stall.
module circular_deque_with_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  kind,
  input  logic signed [31:0]          value,
  output logic                        strobe,
  output logic [1:0]                  status,
  output logic signed [31:0]          element,
  output cdeq_pkg::cnt_t              position,
  output cdeq_pkg::cnt_t              occupancy,
  output logic                        last
);
  import cdeq_pkg::*;

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t             state;
  cnt_t               count;
  logic signed [31:0] key;
  idx_t               k;
  logic               found;
  cnt_t               pos;
  logic               dump;

  cell_ctl_t          ctl;
  logic signed [31:0] cell_q [DEPTH];
  logic signed [31:0] head;
  logic               full;
  logic               empty;
  cnt_t               k_inc;
  logic               is_end;
  logic               match;

  assign busy   = (state != S_IDLE);
  assign head   = cell_q[0];
  assign full   = (count == cnt_t'(DEPTH));
  assign empty  = (count == '0);
  assign k_inc  = cnt_t'(k) + cnt_t'(1);
  assign is_end = (k_inc == count);
  assign match  = (head == key);

  always_comb begin
    ctl.mode  = CELL_HOLD;
    ctl.count = count;
    ctl.value = value;
    if (state == S_WALK) begin
      ctl.mode = CELL_ROTATE;
    end else if (start) begin
      case (kind)
        KIND_PUSH_FRONT: if (!full) ctl.mode = CELL_TAKE_LEFT;
        KIND_PUSH_BACK:  if (!full) ctl.mode = CELL_WRITE;
        KIND_POP_FRONT:  if (!empty) ctl.mode = CELL_TAKE_RIGHT;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    cdeq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (idx_t'(i)),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (head),
      .q       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            element  <= '0;
            position <= '0;
            last     <= 1'b1;
            case (kind)
              KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                strobe <= 1'b1;
                if (full) begin
                  status    <= ST_FULL;
                  occupancy <= count;
                end else begin
                  status    <= ST_OK;
                  count     <= count + cnt_t'(1);
                  occupancy <= count + cnt_t'(1);
                end
              end
              KIND_POP_FRONT, KIND_POP_BACK: begin
                strobe <= 1'b1;
                if (empty) begin
                  status    <= ST_EMPTY;
                  occupancy <= count;
                end else begin
                  status    <= ST_OK;
                  count     <= count - cnt_t'(1);
                  occupancy <= count - cnt_t'(1);
                end
              end
              KIND_SEARCH, KIND_DUMP: begin
                if (empty) begin
                  strobe    <= 1'b1;
                  status    <= ST_EMPTY;
                  occupancy <= count;
                end else begin
                  state <= S_WALK;
                  dump  <= (kind == KIND_DUMP);
                  key   <= value;
                  k     <= '0;
                  found <= 1'b0;
                  pos   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          k         <= k + idx_t'(1);
          occupancy <= count;
          if (dump) begin
            strobe   <= 1'b1;
            status   <= ST_OK;
            element  <= head;
            position <= '0;
            last     <= is_end;
          end else begin
            if (!found && match) begin
              found <= 1'b1;
              pos   <= k_inc;
            end
            if (is_end) begin
              strobe  <= 1'b1;
              element <= '0;
              last    <= 1'b1;
              if (found) begin
                status   <= ST_OK;
                position <= pos;
              end else if (match) begin
                status   <= ST_OK;
                position <= k_inc;
              end else begin
                status   <= ST_NOTFOUND;
                position <= '0;
              end
            end
          end
          if (is_end) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
